// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// cond must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hw/rtl/ssbt_pkg.sv -----
// Types and constants of the sparse basis transform.
package ssbt_pkg;

    localparam int OPERAND_W = 32;
    localparam int ACC_W     = 64;
    localparam int RESULT_W  = 48;
    localparam int FRAC_DROP = 24;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register select is paddr[2]
    localparam logic CFG_IDX_ORBITAL_COUNT = 1'b0;
    localparam logic [6:0] ORBITAL_COUNT_RESET = 7'd64;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_VALUE = 1'b1;

    typedef struct packed {
        logic                         command;
        logic [7:0]                   basis_index;
        logic [5:0]                   orbital_index;
        logic signed [OPERAND_W-1:0]  operand_value;
        logic                         last_of_point;
    } t_in_word;

    typedef struct packed {
        logic [5:0]                   result_orbital;
        logic signed [RESULT_W-1:0]   orbital_value;
        logic                         last_result;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } t_state;

endpackage

// ----- hw/rtl/ssbt_ram.sv -----
// Simple dual-port RAM, one write port and one registered read port.
module ssbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sparse_skip_basis_transform.sv -----
// Sparse basis-to-orbital transform: top level with sequencer and shared MAC.
//
// Load words (command 0) write one Q8.24 coefficient. A value word (command 1)
// with a nonzero value and an in-range basis index runs one multiply-accumulate
// per orbital through a single 32x32 multiplier and a saturating 64-bit adder,
// one orbital per cycle with a three-stage pipe (read, multiply, add/write
// back). A zero or out-of-range value runs no multiply-accumulate. A value
// word marked last of point then emits orbital_count results, read one by one
// from the accumulator RAM through a read state and a wait state that holds
// while the output is stalled; the accumulators are cleared as the final
// result is handed to the output register. The input is stalled while a word
// is in progress. Results are rounded to nearest (ties up) to 24 fraction
// bits; coefficients never loaded read as undefined.
`include "assert_macros.svh"

module sparse_skip_basis_transform #(
    parameter int BASIS_MAX   = 256,
    parameter int ORBITAL_MAX = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    input  ssbt_pkg::t_in_word                  i_in_data,
    output logic                                o_in_stall,

    output logic                                o_out_valid,
    output ssbt_pkg::t_out_word                 o_out_data,
    input  logic                                i_out_stall,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssbt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ssbt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ssbt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CDEPTH = BASIS_MAX * ORBITAL_MAX;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int IW     = (ORBITAL_MAX > 1) ? $clog2(ORBITAL_MAX) : 1;
    localparam int CW     = $clog2(ORBITAL_MAX + 1);
    localparam int OW     = ssbt_pkg::OPERAND_W;
    localparam int AccW   = ssbt_pkg::ACC_W;
    localparam int RW     = ssbt_pkg::RESULT_W;
    localparam int FD     = ssbt_pkg::FRAC_DROP;

    ssbt_pkg::t_state r_state, n_state;
    logic [6:0]       r_orbital_count;
    logic [CW-1:0]    eff_count;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_iss, n_iss;
    logic [CAW-1:0]   r_base;
    logic signed [OW-1:0] r_value;
    logic             r_last;

    logic             r_p1_valid, n_p1_valid;
    logic [IW-1:0]    r_p1_idx;
    logic             r_p2_valid;
    logic [IW-1:0]    r_p2_idx;
    logic signed [AccW-1:0] r_prod, r_acc_q;
    logic [ORBITAL_MAX-1:0] r_acc_vld, n_acc_vld;
    logic             r_rd_vld;

    logic             r_out_valid, n_out_valid;
    ssbt_pkg::t_out_word r_out_data;

    logic             in_acc, cfg_wr, out_free, emit_last, load_out;
    logic             coef_we, coef_re, acc_re, acc_we;
    logic [CAW-1:0]   coef_waddr, coef_raddr;
    logic [IW-1:0]    acc_raddr;
    logic [OW-1:0]    coef_rdata;
    logic [AccW-1:0]  acc_rdata, acc_wdata;
    logic signed [AccW-1:0] prod, emit_acc;
    logic [AccW:0]    sum_ext;
    logic             in_mac_ok, load_ok;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ssbt_pkg::CFG_IDX_ORBITAL_COUNT)
                  ? {{(ssbt_pkg::APB_DATA_W-7){1'b0}}, r_orbital_count}
                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbital_count <= ssbt_pkg::ORBITAL_COUNT_RESET;
        end else if (cfg_wr && paddr[2] == ssbt_pkg::CFG_IDX_ORBITAL_COUNT) begin
            r_orbital_count <= pwdata[6:0];
        end
    end

    always_comb begin
        if (r_orbital_count == 7'd0) begin
            eff_count = CW'(1);
        end else if (32'(r_orbital_count) > 32'(ORBITAL_MAX)) begin
            eff_count = CW'(ORBITAL_MAX);
        end else begin
            eff_count = CW'(r_orbital_count);
        end
    end

    // input decode
    assign o_in_stall = (r_state != ssbt_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_ok    = (32'(i_in_data.basis_index) < 32'(BASIS_MAX))
                     && (32'(i_in_data.orbital_index) < 32'(ORBITAL_MAX));
    assign in_mac_ok  = (i_in_data.operand_value != '0)
                     && (32'(i_in_data.basis_index) < 32'(BASIS_MAX));
    assign coef_we    = in_acc && (i_in_data.command == ssbt_pkg::CMD_LOAD) && load_ok;
    assign coef_waddr = CAW'(32'(i_in_data.basis_index) * 32'(ORBITAL_MAX)
                           + 32'(i_in_data.orbital_index));

    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_last = (r_iss + CW'(1)) == r_count;
    assign load_out  = (r_state == ssbt_pkg::ST_EMIT_WAIT) && out_free;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_iss       = r_iss;
        n_p1_valid  = 1'b0;
        n_acc_vld   = r_acc_vld;
        n_out_valid = r_out_valid && i_out_stall;
        coef_re     = 1'b0;
        acc_re      = 1'b0;
        coef_raddr  = r_base + CAW'(r_iss[IW-1:0]);
        acc_raddr   = r_iss[IW-1:0];
        if (r_p2_valid) begin
            n_acc_vld[r_p2_idx] = 1'b1;
        end
        case (r_state)
            ssbt_pkg::ST_IDLE: begin
                if (in_acc && i_in_data.command == ssbt_pkg::CMD_VALUE) begin
                    n_count = eff_count;
                    n_iss   = '0;
                    if (in_mac_ok) begin
                        n_state = ssbt_pkg::ST_MAC;
                    end else if (i_in_data.last_of_point) begin
                        n_state = ssbt_pkg::ST_EMIT_RD;
                    end
                end
            end
            ssbt_pkg::ST_MAC: begin
                if (r_iss < r_count) begin
                    coef_re    = 1'b1;
                    acc_re     = 1'b1;
                    n_p1_valid = 1'b1;
                    n_iss      = r_iss + CW'(1);
                end else if (!r_p1_valid && !r_p2_valid) begin
                    n_iss   = '0;
                    n_state = r_last ? ssbt_pkg::ST_EMIT_RD : ssbt_pkg::ST_IDLE;
                end
            end
            ssbt_pkg::ST_EMIT_RD: begin
                acc_re  = 1'b1;
                n_state = ssbt_pkg::ST_EMIT_WAIT;
            end
            ssbt_pkg::ST_EMIT_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (emit_last) begin
                        n_acc_vld = '0;
                        n_state   = ssbt_pkg::ST_IDLE;
                    end else begin
                        n_iss   = r_iss + CW'(1);
                        n_state = ssbt_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ssbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssbt_pkg::ST_IDLE;
            r_count     <= CW'(1);
            r_iss       <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_acc_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_iss       <= n_iss;
            r_p1_valid  <= n_p1_valid;
            r_p2_valid  <= r_p1_valid;
            r_acc_vld   <= n_acc_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // shared multiply and saturating accumulate
    assign prod    = $signed(coef_rdata) * r_value;
    assign sum_ext = {r_acc_q[AccW-1], r_acc_q} + {r_prod[AccW-1], r_prod};

    always_comb begin
        if (sum_ext[AccW] != sum_ext[AccW-1]) begin
            acc_wdata = sum_ext[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        end else begin
            acc_wdata = sum_ext[AccW-1:0];
        end
    end
    assign acc_we = r_p2_valid;

    // round to nearest, ties up; the 40-bit quotient plus one always fits 48 bits
    assign emit_acc = r_rd_vld ? $signed(acc_rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_base  <= CAW'(32'(i_in_data.basis_index) * 32'(ORBITAL_MAX));
            r_value <= i_in_data.operand_value;
            r_last  <= i_in_data.last_of_point;
        end
        r_p1_idx <= r_iss[IW-1:0];
        r_p2_idx <= r_p1_idx;
        if (r_p1_valid) begin
            r_prod  <= prod;
            r_acc_q <= r_acc_vld[r_p1_idx] ? $signed(acc_rdata) : '0;
        end
        if (r_state == ssbt_pkg::ST_EMIT_RD) begin
            r_rd_vld <= r_acc_vld[r_iss[IW-1:0]];
        end
        if (load_out) begin
            r_out_data.result_orbital <= 6'(r_iss[IW-1:0]);
            r_out_data.orbital_value  <=
                {{(RW-(AccW-FD)){emit_acc[AccW-1]}}, emit_acc[AccW-1:FD]}
                + {{(RW-1){1'b0}}, emit_acc[FD-1]};
            r_out_data.last_result    <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ssbt_ram #(
        .WIDTH (OW),
        .DEPTH (CDEPTH),
        .AW    (CAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in_data.operand_value),
        .i_re    (coef_re),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    ssbt_ram #(
        .WIDTH (AccW),
        .DEPTH (ORBITAL_MAX),
        .AW    (IW)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_p2_idx),
        .i_wdata (acc_wdata),
        .i_re    (acc_re),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    `ASSERT_AT(a_wb_idx_in_range, i_clk, i_rst_n, r_p2_valid |-> (CW'(r_p2_idx) < r_count), "accumulator write beyond orbital count")
    `ASSERT_NEVER(a_emit_while_mac, i_clk, i_rst_n, (r_state == ssbt_pkg::ST_EMIT_RD || r_state == ssbt_pkg::ST_EMIT_WAIT) && (r_p1_valid || r_p2_valid), "emit started with MAC pipe busy")
    `ASSERT_AT(a_acc_cleared, i_clk, i_rst_n, (load_out && emit_last) |=> (r_acc_vld == '0), "accumulators not cleared after final result")

endmodule

// ----- tb/ssbt_checker.sv -----
// Checker for the sparse basis transform: predicts orbital words and compares them.
module ssbt_checker
    import ssbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_words_checked,
    output int                    o_points
);
    localparam int ORB_SLOTS   = 64;
    localparam int BASIS_SLOTS = 256;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [OPERAND_W-1:0] coef_mem [0:BASIS_SLOTS*ORB_SLOTS-1];
    logic signed [ACC_W-1:0]     orbital_acc [0:ORB_SLOTS-1];
    logic [6:0]                  count_reg = ORBITAL_COUNT_RESET;
    t_out_word                   expected_words [$];

    int mismatches    = 0;
    int pending       = 0;
    int words_checked = 0;
    int points        = 0;

    assign o_mismatches    = mismatches;
    assign o_pending       = pending;
    assign o_words_checked = words_checked;
    assign o_points        = points;

    function automatic int active_orbitals(input logic [6:0] r);
        if (r == 7'd0)
            return 1;
        if (r > 7'(ORB_SLOTS))
            return ORB_SLOTS;
        return int'(r);
    endfunction

    function automatic logic signed [ACC_W-1:0] product_q48(
        input logic signed [OPERAND_W-1:0] a,
        input logic signed [OPERAND_W-1:0] b
    );
        logic signed [ACC_W-1:0] wa;
        logic signed [ACC_W-1:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    // floor, then add the first dropped bit: nearest, ties up; never hits 48-bit limits
    function automatic logic signed [RESULT_W-1:0] round_q24(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0] whole;
        whole = a >>> FRAC_DROP;
        return whole[RESULT_W-1:0] + {{(RESULT_W-1){1'b0}}, a[FRAC_DROP-1]};
    endfunction

    always @(posedge i_clk) begin : track
        t_in_word                w;
        t_out_word               e;
        int                      n;
        int                      k;
        if (!i_rst_n) begin
            for (k = 0; k < ORB_SLOTS; k++)
                orbital_acc[k] = '0;
            count_reg = ORBITAL_COUNT_RESET;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected orbital word orbital=%0d value=%0d last=%0b",
                             $time, i_out_data.result_orbital, i_out_data.orbital_value,
                             i_out_data.last_result);
                end else begin
                    e = expected_words.pop_front();
                    words_checked++;
                    if (i_out_data.result_orbital !== e.result_orbital) begin
                        mismatches++;
                        $display("%0t: result_orbital expected %0d got %0d",
                                 $time, e.result_orbital, i_out_data.result_orbital);
                    end
                    if (i_out_data.orbital_value !== e.orbital_value) begin
                        mismatches++;
                        $display("%0t: orbital %0d value expected %0d got %0d", $time,
                                 e.result_orbital, e.orbital_value, i_out_data.orbital_value);
                    end
                    if (i_out_data.last_result !== e.last_result) begin
                        mismatches++;
                        $display("%0t: orbital %0d last_result expected %0b got %0b", $time,
                                 e.result_orbital, e.last_result, i_out_data.last_result);
                    end
                end
            end

            if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_ORBITAL_COUNT)
                count_reg = pwdata[6:0];

            if (i_in_valid && !i_in_stall) begin
                w = i_in_data;
                n = active_orbitals(count_reg);
                if (w.command == CMD_LOAD) begin
                    coef_mem[{w.basis_index, w.orbital_index}] = w.operand_value;
                end else begin
                    if (w.operand_value != '0) begin
                        for (k = 0; k < n; k++)
                            orbital_acc[k] = sat_add(orbital_acc[k],
                                product_q48(coef_mem[{w.basis_index, 6'(k)}], w.operand_value));
                    end
                    if (w.last_of_point) begin
                        for (k = 0; k < n; k++) begin
                            e.result_orbital = 6'(k);
                            e.orbital_value  = round_q24(orbital_acc[k]);
                            e.last_result    = (k == n - 1);
                            expected_words.push_back(e);
                        end
                        for (k = 0; k < ORB_SLOTS; k++)
                            orbital_acc[k] = '0;
                        points++;
                    end
                end
            end
        end
        pending = expected_words.size();
    end
endmodule

// ----- tb/tb_sparse_skip_basis_transform.sv -----
// Testbench top for the sparse basis transform: stimulus, idling and verdict.
module tb_sparse_skip_basis_transform;
    import ssbt_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_LIMIT   = 2000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_word;
    logic                  out_stall = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int words_checked;
    int points;

    logic [63:0] coef_loaded [0:255] = '{default: '0};
    logic [7:0]  ready_rows [$];
    int          cur_count   = 64;
    logic        calm        = 1'b0;
    int          loads_sent  = 0;
    int          values_sent = 0;
    int          stall_hold  = 0;
    int          idle_cycles = 0;
    logic [6:0]  odd_count;

    sparse_skip_basis_transform dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_word),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ssbt_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_word),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_points        (points)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return 32'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
        endcase
    endfunction

    always @(posedge clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_hold <= pick_gap();
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles without progress", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input t_in_word w);
        int g;
        g = pick_gap();
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    task automatic load_coef(input logic [7:0] b, input logic [5:0] o,
                             input logic [31:0] v, input logic last);
        t_in_word w;
        w.command       = CMD_LOAD;
        w.basis_index   = b;
        w.orbital_index = o;
        w.operand_value = v;
        w.last_of_point = last;
        coef_loaded[b][o] = 1'b1;
        loads_sent++;
        send_word(w);
    endtask

    task automatic put_value(input logic [7:0] b, input logic [31:0] v, input logic last);
        t_in_word w;
        w.command       = CMD_VALUE;
        w.basis_index   = b;
        w.orbital_index = 6'($urandom_range(0, 63));
        w.operand_value = v;
        w.last_of_point = last;
        values_sent++;
        send_word(w);
    endtask

    task automatic set_orbital_count(input logic [6:0] v);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_ORBITAL_COUNT, 2'b00};
        pwdata  <= {25'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_count = (v == 7'd0) ? 1 : (v > 7'd64) ? 64 : int'(v);
    endtask

    task automatic refresh_ready_rows();
        logic [63:0] need;
        int b;
        need = (cur_count >= 64) ? '1 : ((64'd1 << cur_count) - 64'd1);
        ready_rows.delete();
        for (b = 0; b < 256; b++)
            if ((coef_loaded[b] & need) == need)
                ready_rows.push_back(8'(b));
    endtask

    task automatic fill_row(input logic [7:0] b);
        int o;
        for (o = 0; o < cur_count; o++)
            load_coef(b, 6'(o), rand_operand(), 1'($urandom_range(0, 1)));
        ready_rows.push_back(b);
    endtask

    task automatic stray_load();
        load_coef(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), rand_operand(),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic random_point();
        int len;
        int k;
        logic fin;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
            fin = (k == len - 1);
            if ($urandom_range(0, 19) == 0)
                stray_load();
            if ($urandom_range(0, 6) == 0)
                put_value(8'($urandom_range(0, 255)), 32'd0, fin);
            else
                put_value(ready_rows[$urandom_range(0, ready_rows.size() - 1)],
                          rand_operand(), fin);
        end
    endtask

    task automatic random_phase(input logic [6:0] reg_val, input int n_values,
                                input logic quiet);
        int stop;
        int r;
        set_orbital_count(reg_val);
        calm = quiet;
        refresh_ready_rows();
        if (ready_rows.size() == 0)
            fill_row(8'($urandom_range(0, 255)));
        stop = values_sent + n_values;
        while (values_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                fill_row(8'($urandom_range(0, 255)));
            else if (r < 14)
                stray_load();
            else
                random_point();
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // loads at the reset count; a load marked last emits nothing
        load_coef(8'd0,   6'd0,  32'h7FFF_FFFF, 1'b1);
        load_coef(8'd255, 6'd0,  32'h8000_0000, 1'b0);
        load_coef(8'd1,   6'd0,  32'h0000_0001, 1'b0);
        load_coef(8'd170, 6'd63, 32'h8000_0001, 1'b1);
        load_coef(8'd85,  6'd42, 32'h1234_5678, 1'b0);
        // zero value on an unloaded row: skipped, all 64 orbitals read back zero
        put_value(8'd200, 32'd0, 1'b1);

        set_orbital_count(7'd1);
        // positive saturation
        put_value(8'd0, 32'h7FFF_FFFF, 1'b0);
        put_value(8'd0, 32'h7FFF_FFFF, 1'b0);
        put_value(8'd0, 32'h7FFF_FFFF, 1'b1);
        // negative saturation
        put_value(8'd0, 32'h8000_0000, 1'b0);
        put_value(8'd0, 32'h8000_0000, 1'b0);
        put_value(8'd0, 32'h8000_0000, 1'b1);
        // most negative squared
        put_value(8'd255, 32'h8000_0000, 1'b1);
        // rounding: half up, minus half to zero, just below minus half
        put_value(8'd1, 32'h0080_0000, 1'b1);
        put_value(8'd1, 32'hFF80_0000, 1'b1);
        put_value(8'd1, 32'hFF7F_FFFF, 1'b1);
        // zero skipped mid-point, tiny product rounds away
        put_value(8'd200, 32'd0, 1'b0);
        put_value(8'd1, 32'h0000_0001, 1'b1);

        odd_count = 7'($urandom_range(2, 63));
        random_phase(7'd64,  16, 1'b0);
        random_phase(7'd127, 16, 1'b1);
        random_phase(7'd0,   16, 1'b0);
        random_phase(7'd7,   16, 1'b0);
        random_phase(7'd1,   16, 1'b1);
        random_phase(7'd33,  16, 1'b0);
        random_phase(odd_count, 16, 1'b0);
        random_phase(7'd64,  16, 1'b1);

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d coefficient loads and %0d basis values, %0d points, %0d words checked",
                 loads_sent, values_sent, points, words_checked);
        $display("orbital_count went through 64 (reset), 1, 64, 127, 0, 7, 1, 33, %0d, 64",
                 odd_count);
        if (pending != 0)
            $display("%0d orbital words never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
